// ----- hw/rtl/gmd_pkg.sv -----
// Shared types and constants of the grid local maximum detector.
package gmd_pkg;

    localparam int CFG_DATA_BITS  = 13;
    localparam int WIDTH_REG_BITS = 9;
    localparam int ROW_BITS       = 13;
    localparam int MAX_ROWS       = 4096;
    localparam int PEAK_ROW_BITS  = 12;
    localparam int PEAK_COL_BITS  = 8;

    typedef logic [0:0] t_cfg_index;

    localparam t_cfg_index REG_GRID_WIDTH  = 1'b0;
    localparam t_cfg_index REG_GRID_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PEAK_ROW_BITS-1:0] peak_row;
        logic [PEAK_COL_BITS-1:0] peak_col;
    } t_peak;

endpackage

// ----- hw/rtl/gmd_in_if.sv -----
// Input channel: grid cell values and flush items.
interface gmd_in_if #(
    parameter int DATA_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic signed [DATA_BITS-1:0] cell_value;

    modport source (output valid, mode, cell_value, input ready);
    modport sink   (input valid, mode, cell_value, output ready);
endinterface

// ----- hw/rtl/gmd_out_if.sv -----
// Output channel: row and column of each detected peak.
interface gmd_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [gmd_pkg::PEAK_ROW_BITS-1:0]    peak_row;
    logic [gmd_pkg::PEAK_COL_BITS-1:0]    peak_col;

    modport source (output valid, peak_row, peak_col, input ready);
    modport sink   (input valid, peak_row, peak_col, output ready);
endinterface

// ----- hw/rtl/gmd_cell.sv -----
// One column cell of the two line buffers: center and upper value, shifted along the chain.
module gmd_cell #(
    parameter int DATA_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_shift,
    input  logic                        i_entry,
    input  logic signed [DATA_BITS-1:0] i_new_value,
    input  logic signed [DATA_BITS-1:0] i_center_exit,
    input  logic signed [DATA_BITS-1:0] i_prev_center,
    input  logic signed [DATA_BITS-1:0] i_prev_upper,
    output logic signed [DATA_BITS-1:0] o_center,
    output logic signed [DATA_BITS-1:0] o_upper
);

    logic signed [DATA_BITS-1:0] r_center;
    logic signed [DATA_BITS-1:0] r_upper;
    logic signed [DATA_BITS-1:0] n_center;
    logic signed [DATA_BITS-1:0] n_upper;

    // entry cell loads fresh data, the others take their left neighbor
    always_comb begin
        n_center = i_entry ? i_new_value   : i_prev_center;
        n_upper  = i_entry ? i_center_exit : i_prev_upper;
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_center <= n_center;
            r_upper  <= n_upper;
        end
    end

    assign o_center = r_center;
    assign o_upper  = r_upper;

endmodule

// ----- hw/rtl/gmd_peak_buf.sv -----
// Output register with skid stage for peak results.
module gmd_peak_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gmd_pkg::t_peak    i_peak,
    output logic              o_ready,
    gmd_out_if.source         o_peak
);

    logic           r_main_valid;
    logic           r_skid_valid;
    gmd_pkg::t_peak r_main;
    gmd_pkg::t_peak r_skid;
    logic           n_main_valid;
    logic           n_skid_valid;
    logic           pop;

    assign pop = r_main_valid & o_peak.ready;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        if (pop) begin
            if (r_skid_valid) begin
                n_skid_valid = 1'b0;
            end else begin
                n_main_valid = i_push;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                n_skid_valid = 1'b1;
            end else begin
                n_main_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_main <= r_skid_valid ? r_skid : i_peak;
        end else if (i_push && !r_main_valid) begin
            r_main <= i_peak;
        end
        if (!pop && i_push && r_main_valid) begin
            r_skid <= i_peak;
        end
    end

    assign o_ready         = !r_skid_valid;
    assign o_peak.valid    = r_main_valid;
    assign o_peak.peak_row = r_main.peak_row;
    assign o_peak.peak_col = r_main.peak_col;

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid stage holds a result while the output stage is empty");

    a_skid_drains_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && o_peak.ready) |=> (r_main == $past(r_skid) && !r_skid_valid))
        else $error("skid result not moved to the output stage");

endmodule

// ----- hw/rtl/grid_local_maximum_detector.sv -----
// Top level: 4-neighbor local maximum detector over a raster grid.
//
//   channel   dir  handshake          payload
//   i_in      in   valid/ready        mode, cell_value
//   o_peak    out  valid/ready        peak_row, peak_col
//   cfg       in   i_cfg_we (write)   i_cfg_index, i_cfg_data
//
// One item per cycle while i_in.ready is high; peaks are registered in the output buffer.
// Both line buffers are a chain of MAX_COLS cells that all shift on each used request,
// so the judgement needs no memory port and is combinational.
// Reset (synchronous) clears counters and sets width and height to 2; buffers are not cleared.
// i_in.ready drops only while the skid stage holds a second waiting peak.
module grid_local_maximum_detector #(
    parameter int MAX_COLS  = 256,
    parameter int DATA_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  gmd_pkg::t_cfg_index                  i_cfg_index,
    input  logic [gmd_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    gmd_in_if.sink                               i_in,
    gmd_out_if.source                            o_peak
);

    localparam int CB = $clog2(MAX_COLS);
    localparam int WB = $clog2(MAX_COLS + 1);
    localparam int RB = gmd_pkg::ROW_BITS;

    logic [gmd_pkg::WIDTH_REG_BITS-1:0] r_grid_width;
    logic [RB-1:0]                      r_grid_height;
    logic [CB-1:0]                      r_col;
    logic [RB-1:0]                      r_row;
    logic [CB-1:0]                      n_col;
    logic [RB-1:0]                      n_row;
    logic signed [DATA_BITS-1:0]        r_left;

    logic [WB-1:0]               w;
    logic [RB-1:0]               h;
    logic [CB-1:0]               entry_idx;
    logic                        flush;
    logic                        accept;
    logic                        act;
    logic                        peak;
    logic                        push;
    logic                        buf_ready;
    logic signed [DATA_BITS-1:0] value;
    logic signed [DATA_BITS-1:0] me;
    logic signed [DATA_BITS-1:0] up;
    logic signed [DATA_BITS-1:0] right;
    logic                        last_col;
    gmd_pkg::t_peak              peak_data;

    logic signed [DATA_BITS-1:0] center_chain [MAX_COLS];
    logic signed [DATA_BITS-1:0] upper_chain  [MAX_COLS];

    // clamp the geometry registers to the supported range
    always_comb begin
        if (32'(r_grid_width) > 32'(MAX_COLS)) begin
            w = WB'(MAX_COLS);
        end else if (r_grid_width < gmd_pkg::WIDTH_REG_BITS'(2)) begin
            w = WB'(2);
        end else begin
            w = WB'(r_grid_width);
        end
        if (r_grid_height > RB'(gmd_pkg::MAX_ROWS)) begin
            h = RB'(gmd_pkg::MAX_ROWS);
        end else if (r_grid_height < RB'(2)) begin
            h = RB'(2);
        end else begin
            h = r_grid_height;
        end
    end

    assign entry_idx = CB'(WB'(MAX_COLS) - w);

    assign value    = signed'(DATA_BITS'(i_in.cell_value));
    assign flush    = i_in.mode;
    assign accept   = i_in.valid & buf_ready;
    // drop items whose mode does not match the current phase
    assign act      = accept & (flush == (r_row == h));
    assign last_col = (WB'(r_col) == (w - WB'(1)));

    // oldest entries of the chains are the cells of the row being judged
    assign me    = center_chain[MAX_COLS-1];
    assign right = center_chain[MAX_COLS-2];
    assign up    = upper_chain[MAX_COLS-1];

    genvar k;
    generate
        for (k = 0; k < MAX_COLS; k++) begin : g_cell
            logic signed [DATA_BITS-1:0] prev_center;
            logic signed [DATA_BITS-1:0] prev_upper;
            if (k == 0) begin : g_first
                assign prev_center = '0;
                assign prev_upper  = '0;
            end else begin : g_next
                assign prev_center = center_chain[k-1];
                assign prev_upper  = upper_chain[k-1];
            end
            gmd_cell #(
                .DATA_BITS (DATA_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_shift       (act),
                .i_entry       (entry_idx == CB'(k)),
                .i_new_value   (value),
                .i_center_exit (me),
                .i_prev_center (prev_center),
                .i_prev_upper  (prev_upper),
                .o_center      (center_chain[k]),
                .o_upper       (upper_chain[k])
            );
        end
    endgenerate

    always_comb begin
        peak = 1'b1;
        if (r_row >= RB'(2) && me < up) begin
            peak = 1'b0;
        end
        if (!flush && me < value) begin
            peak = 1'b0;
        end
        if ((WB'(r_col) + WB'(1)) < w && me < right) begin
            peak = 1'b0;
        end
        if (r_col != '0 && me < r_left) begin
            peak = 1'b0;
        end
    end

    assign push               = act & (r_row != '0) & peak;
    assign peak_data.peak_row = gmd_pkg::PEAK_ROW_BITS'(r_row - RB'(1));
    assign peak_data.peak_col = gmd_pkg::PEAK_COL_BITS'(r_col);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (act) begin
            if (last_col) begin
                n_col = '0;
                n_row = (r_row == h) ? '0 : r_row + RB'(1);
            end else begin
                n_col = r_col + CB'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= gmd_pkg::WIDTH_REG_BITS'(2);
            r_grid_height <= RB'(2);
            r_col         <= '0;
            r_row         <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gmd_pkg::REG_GRID_WIDTH: begin
                    r_grid_width <= i_cfg_data[gmd_pkg::WIDTH_REG_BITS-1:0];
                end
                gmd_pkg::REG_GRID_HEIGHT: begin
                    r_grid_height <= i_cfg_data[RB-1:0];
                end
                default: begin
                end
            endcase
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // hold the judged cell as left neighbor of the next one
    always_ff @(posedge i_clk) begin
        if (act) begin
            r_left <= me;
        end
    end

    gmd_peak_buf u_peak_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_peak  (peak_data),
        .o_ready (buf_ready),
        .o_peak  (o_peak)
    );

    assign i_in.ready = buf_ready;

    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_col == '0 && r_row == '0))
        else $error("configuration write did not restart the grid");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WB'(r_col) < w)
        else $error("column counter beyond grid width");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= h)
        else $error("row counter beyond grid height");

    a_no_peak_first_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_row != '0 && act))
        else $error("peak reported while the first row is still arriving");

endmodule

// ----- tb/sv/gmd_peak_checker.sv -----
// Peak checker: predicts the expected peaks from accepted requests and compares them.
`timescale 1ns / 1ps

module gmd_peak_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  gmd_pkg::t_cfg_index               i_cfg_index,
    input  logic [gmd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic                              i_in_mode,
    input  logic signed [15:0]                i_in_cell_value,
    input  logic                              i_peak_valid,
    input  logic                              i_peak_ready,
    input  logic [gmd_pkg::PEAK_ROW_BITS-1:0] i_peak_row,
    input  logic [gmd_pkg::PEAK_COL_BITS-1:0] i_peak_col,
    output int                                o_errors,
    output int                                o_pending
);

    localparam int unsigned LINE_CELLS = 256;

    logic signed [15:0] upper_row [LINE_CELLS];
    logic signed [15:0] center_row [LINE_CELLS];
    int unsigned        col_idx;
    int unsigned        row_idx;
    logic [8:0]         width_reg;
    logic [12:0]        height_reg;
    gmd_pkg::t_peak     peaks_due [$];
    int                 error_count = 0;

    assign o_errors = error_count;

    // Judge the cell one row above the arriving request, then store the request.
    task automatic judge_cell(input logic is_flush, input logic signed [15:0] value);
        int unsigned        w;
        int unsigned        h;
        int unsigned        c;
        int unsigned        r;
        logic signed [15:0] me;
        bit                 is_peak;
        gmd_pkg::t_peak     due;

        w = (width_reg < 2) ? 2 : (width_reg > LINE_CELLS) ? LINE_CELLS : width_reg;
        h = (height_reg < 2) ? 2 : (height_reg > gmd_pkg::MAX_ROWS) ? gmd_pkg::MAX_ROWS
                                                                      : height_reg;
        if (col_idx >= w) col_idx = 0;
        if (row_idx > h) row_idx = 0;

        // drop requests of the wrong kind for the current phase
        if (is_flush != (row_idx == h)) return;

        c = col_idx;
        if (row_idx > 0) begin
            r = row_idx - 1;
            me = center_row[c];
            is_peak = 1'b1;
            if (r >= 1 && me < upper_row[c]) is_peak = 1'b0;
            if (!is_flush && me < value) is_peak = 1'b0;
            if (c + 1 < w) begin
                if (me < center_row[c + 1]) is_peak = 1'b0;
            end
            upper_row[c] = center_row[c];
            // left neighbor has already moved up into the upper row
            if (c >= 1) begin
                if (me < upper_row[c - 1]) is_peak = 1'b0;
            end
            if (is_peak) begin
                due.peak_row = gmd_pkg::PEAK_ROW_BITS'(r);
                due.peak_col = gmd_pkg::PEAK_COL_BITS'(c);
                peaks_due.push_back(due);
            end
        end else begin
            upper_row[c] = center_row[c];
        end
        if (!is_flush) center_row[c] = value;

        col_idx = c + 1;
        if (col_idx >= w) begin
            col_idx = 0;
            row_idx++;
            if (row_idx > h) row_idx = 0;
        end
    endtask

    always @(posedge i_clk) begin
        gmd_pkg::t_peak want;
        if (!i_rst_n) begin
            col_idx    = 0;
            row_idx    = 0;
            width_reg  = 9'd2;
            height_reg = 13'd2;
            peaks_due.delete();
        end else begin
            if (i_peak_valid && i_peak_ready) begin
                if (peaks_due.size() == 0) begin
                    $display("%0t: unexpected peak row %0d col %0d", $time, i_peak_row,
                             i_peak_col);
                    error_count++;
                end else begin
                    want = peaks_due.pop_front();
                    if (i_peak_row !== want.peak_row) begin
                        $display("%0t: peak_row mismatch: expected %0d, got %0d", $time,
                                 want.peak_row, i_peak_row);
                        error_count++;
                    end
                    if (i_peak_col !== want.peak_col) begin
                        $display("%0t: peak_col mismatch: expected %0d, got %0d", $time,
                                 want.peak_col, i_peak_col);
                        error_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == gmd_pkg::REG_GRID_WIDTH) width_reg = i_cfg_data[8:0];
                else height_reg = i_cfg_data[12:0];
                col_idx = 0;
                row_idx = 0;
            end
            if (i_in_valid && i_in_ready) judge_cell(i_in_mode, i_in_cell_value);
        end
        o_pending = peaks_due.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the detector testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_ITEMS     = 700;
    localparam int DRAIN_CYCLES     = 8;
    localparam int END_CYCLES       = 20;
    localparam int HOLD_OFF_CYCLES  = 80;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int WIDE_CUT         = 300;
    localparam int TALL_CUT         = 60;

    typedef enum {VALS_FULL, VALS_NARROW, VALS_FLAT, VALS_EXTREME} t_value_mix;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                cfg_we;
    gmd_pkg::t_cfg_index                 cfg_index;
    logic [gmd_pkg::CFG_DATA_BITS-1:0]   cfg_data;

    int  mismatch_count;
    int  peaks_pending;
    int  quiet_cycles = 0;
    int  grid_items = 0;
    int  cur_w = 2;
    int  cur_h = 2;
    bit  gaps_on = 1'b1;
    bit  noise_on = 1'b0;
    int  hold_offs_asked = 0;
    int  hold_offs_done = 0;

    gmd_in_if #(.DATA_BITS(16)) in_ch ();
    gmd_out_if                  peak_ch ();

    grid_local_maximum_detector #(
        .MAX_COLS  (256),
        .DATA_BITS (16)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_peak      (peak_ch)
    );

    gmd_peak_checker peak_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_ch.valid),
        .i_in_ready      (in_ch.ready),
        .i_in_mode       (in_ch.mode),
        .i_in_cell_value (in_ch.cell_value),
        .i_peak_valid    (peak_ch.valid),
        .i_peak_ready    (peak_ch.ready),
        .i_peak_row      (peak_ch.peak_row),
        .i_peak_col      (peak_ch.peak_col),
        .o_errors        (mismatch_count),
        .o_pending       (peaks_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // End the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (peak_ch.valid && peak_ch.ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Peak receiver: random stalls, plus a long hold-off on request.
    initial begin
        peak_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_offs_asked != hold_offs_done) begin
                peak_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                peak_ch.ready <= 1'b1;
                hold_offs_done++;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                peak_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
                peak_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic signed [15:0] pick_value(t_value_mix mix);
        case (mix)
            VALS_NARROW:  return 16'(int'($urandom_range(0, 4)) - 2);
            VALS_EXTREME: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default:      return 16'($urandom);
        endcase
    endfunction

    // Offer one request and hold it until accepted; ends on a falling edge.
    task automatic send_grid_item(input logic is_flush, input logic signed [15:0] value);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            in_ch.valid      <= 1'b0;
            in_ch.mode       <= 1'($urandom);
            in_ch.cell_value <= 16'($urandom);
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= is_flush;
        in_ch.cell_value <= value;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // Write a register once the block has drained; track the effective grid size.
    task automatic write_reg(input gmd_pkg::t_cfg_index idx,
                             input logic [gmd_pkg::CFG_DATA_BITS-1:0] data);
        int raw;
        in_ch.valid <= 1'b0;
        wait (peaks_pending == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        if (idx == gmd_pkg::REG_GRID_WIDTH) begin
            raw = data[8:0];
            cur_w = (raw < 2) ? 2 : (raw > 256) ? 256 : raw;
        end else begin
            raw = data[12:0];
            cur_h = (raw < 2) ? 2 : (raw > gmd_pkg::MAX_ROWS) ? gmd_pkg::MAX_ROWS : raw;
        end
    endtask

    // Send a grid in raster order and its flush row; stop after cut_at cells if given.
    task automatic send_grid(input int w, input int h, input t_value_mix mix,
                             input int cut_at);
        logic signed [15:0] flat_value;
        int                 cells;
        flat_value = 16'($urandom);
        cells = (cut_at >= 0) ? cut_at : w * h;
        for (int k = 0; k < cells; k++) begin
            if (noise_on && $urandom_range(0, 15) == 0) send_grid_item(1'b1, 16'($urandom));
            send_grid_item(1'b0, (mix == VALS_FLAT) ? flat_value : pick_value(mix));
            grid_items++;
        end
        if (cut_at < 0) begin
            for (int k = 0; k < w; k++) begin
                if (noise_on && $urandom_range(0, 15) == 0)
                    send_grid_item(1'b0, 16'($urandom));
                send_grid_item(1'b1, 16'($urandom));
                grid_items++;
            end
        end
    endtask

    initial begin
        t_value_mix mix;
        int         w_raw;
        int         h_raw;
        int         pick;
        int         cut;
        bit         need_cfg;

        in_ch.valid      = 1'b0;
        in_ch.mode       = 1'b0;
        in_ch.cell_value = '0;
        cfg_we           = 1'b0;
        cfg_index        = gmd_pkg::REG_GRID_WIDTH;
        cfg_data         = '0;
        i_rst_n          = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // 2x2 grid from reset values; stray flush in the data rows, stray cell in flush row
        send_grid_item(1'b1, 16'h1234);
        send_grid_item(1'b0, 16'h7FFF);
        send_grid_item(1'b0, 16'h8000);
        send_grid_item(1'b0, 16'h8000);
        send_grid_item(1'b0, 16'h7FFF);
        send_grid_item(1'b0, 16'h0000);
        send_grid_item(1'b1, 16'hFFFF);
        send_grid_item(1'b1, 16'h0000);
        // all cells equal: every cell ties and is a peak
        send_grid(2, 2, VALS_FLAT, -1);
        // cut a grid short; the register write starts a new grid
        send_grid_item(1'b0, 16'h0001);
        send_grid_item(1'b0, 16'h7FFE);
        send_grid_item(1'b0, 16'hFFFF);

        // clamped extremes: the start of the widest row, then of the tallest grid
        write_reg(gmd_pkg::REG_GRID_WIDTH, 13'h1FFF);
        write_reg(gmd_pkg::REG_GRID_HEIGHT, 13'd0);
        send_grid(cur_w, cur_h, VALS_FULL, WIDE_CUT);
        write_reg(gmd_pkg::REG_GRID_WIDTH, 13'd1);
        write_reg(gmd_pkg::REG_GRID_HEIGHT, 13'h1FFF);
        send_grid(cur_w, cur_h, VALS_NARROW, TALL_CUT);

        // fill the block while the receiver holds off
        write_reg(gmd_pkg::REG_GRID_WIDTH, 13'd8);
        write_reg(gmd_pkg::REG_GRID_HEIGHT, 13'd6);
        hold_offs_asked++;
        send_grid(cur_w, cur_h, VALS_FLAT, -1);

        noise_on = 1'b1;
        need_cfg = 1'b0;
        while (grid_items < RANDOM_ITEMS) begin
            pick = need_cfg ? 3 : $urandom_range(0, 3);
            if (pick == 1 || pick == 3) begin
                if ($urandom_range(0, 7) == 0) w_raw = $urandom_range(0, 1);
                else w_raw = $urandom_range(2, ($urandom_range(0, 3) == 0) ? 20 : 8);
                write_reg(gmd_pkg::REG_GRID_WIDTH, {4'($urandom), 9'(w_raw)});
            end
            if (pick == 2 || pick == 3) begin
                if ($urandom_range(0, 7) == 0) h_raw = $urandom_range(0, 1);
                else h_raw = $urandom_range(2, 6);
                write_reg(gmd_pkg::REG_GRID_HEIGHT, 13'(h_raw));
            end
            need_cfg = 1'b0;
            if (grid_items >= RANDOM_ITEMS * 7 / 8) gaps_on = 1'b0;
            mix = t_value_mix'($urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0) begin
                cut = $urandom_range(0, cur_w * cur_h - 1);
                need_cfg = 1'b1;
            end else begin
                cut = -1;
            end
            send_grid(cur_w, cur_h, mix, cut);
        end

        in_ch.valid <= 1'b0;
        wait (peaks_pending == 0);
        repeat (END_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && peaks_pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
